@@ design/ufcd_pkg.sv @@
// Package for the union-find cycle detector: shared widths, memory entry layout
// and the payload structs of both channels.
// No dependencies.
package ufcd_pkg;

  localparam int NODE_W    = 10;
  localparam int MAX_NODES = 2 ** NODE_W;
  localparam int CNT_W     = NODE_W + 1;
  localparam int RANK_W    = 4;
  localparam int RANK_MAX  = 2 ** RANK_W - 1;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  typedef struct packed {
    logic              is_root;
    logic [NODE_W-1:0] parent;
    logic [RANK_W-1:0] rank;
  } node_entry_t;

  localparam int ENTRY_W = $bits(node_entry_t);

  typedef struct packed {
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dest_node;
    logic              last_edge;
  } in_item_t;

  typedef struct packed {
    logic              closes_cycle;
    logic              cycle_seen;
    logic [NODE_W-1:0] src_root;
    logic [NODE_W-1:0] dest_root;
    logic              bad_node;
    logic              graph_done;
  } out_item_t;

endpackage

@@ design/ufcd_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module ufcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/union_find_cycle_detector_unit.sv @@
// Top level of the union-find cycle detector: control FSM, config register, forest RAM.
// Depends on ufcd_pkg and ufcd_ram.
//
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low;
//   in_data carries one undirected edge. Exactly one result follows, shown on
//   out_data for one cycle while out_valid is high. The receiver cannot stall:
//   each result must be taken in the cycle it appears.
//   Timing: an edge that is out of range, or arrives after the graph closed a loop,
//   gives its result in the cycle after acceptance. Otherwise the work grows
//   with ds and dd, the depths of the endpoints in their trees (at most 10
//   under union by rank), and a rank tie adds a write of the new rank. Each
//   root walk takes one RAM read per level; each compressed node takes a read
//   and a write on the single RAM port, which sets the rate.
//   busy is high while an edge is walked or joined, so one edge is in work at a time.
//   Reset, and every transaction with last_edge set, starts a clearing pass
//   that rewrites every forest entry as a root of rank 0; busy is high
//   throughout. Config writes are taken at any time (pready is tied high);
//   node_count resets to 1024.
module union_find_cycle_detector_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  ufcd_pkg::in_item_t             in_data,
  output logic                           out_valid,
  output ufcd_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ufcd_pkg::APB_AW-1:0]    paddr,
  input  logic [ufcd_pkg::APB_DW-1:0]    pwdata,
  output logic [ufcd_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);

  import ufcd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRQ   = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_CRQ   = 3'd3;
  localparam logic [2:0] S_CRD   = 3'd4;
  localparam logic [2:0] S_JOIN  = 3'd5;
  localparam logic [2:0] S_JOIN2 = 3'd6;
  localparam logic [2:0] S_CLEAR = 3'd7;

  localparam logic [APB_AW-3:0] REG_NODE_COUNT = '0;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  node_count_r;
  logic              flag_r, flag_nxt;
  logic              which_r, which_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [NODE_W-1:0] src_r, src_nxt;
  logic [NODE_W-1:0] dst_r, dst_nxt;
  logic              last_r, last_nxt;
  logic [NODE_W-1:0] sroot_r, sroot_nxt;
  logic [NODE_W-1:0] droot_r, droot_nxt;
  logic [RANK_W-1:0] srank_r, srank_nxt;
  logic [RANK_W-1:0] drank_r, drank_nxt;
  logic [NODE_W-1:0] clr_idx_r, clr_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              ram_we;
  logic [NODE_W-1:0] ram_addr;
  node_entry_t       ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  node_entry_t       rd_entry;

  logic              accept;
  logic              in_bad;
  logic              cfg_wr;
  logic              cfg_hit;
  logic [NODE_W-1:0] cur_root;
  logic [NODE_W-1:0] start_node;

  ufcd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_NODES)
  ) u_forest (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_entry = node_entry_t'(ram_rdata);

  assign accept  = start && !busy;
  assign in_bad  = (node_count_r <= CNT_W'(MAX_NODES)) &&
                   (({1'b0, in_data.src_node} >= node_count_r) ||
                    ({1'b0, in_data.dest_node} >= node_count_r));

  assign cfg_hit = (paddr[APB_AW-1:2] == REG_NODE_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? APB_DW'(node_count_r) : '0;

  assign cur_root   = which_r ? droot_r : sroot_r;
  assign start_node = which_r ? dst_r : src_r;

  always_comb begin
    logic phase_done;
    phase_done    = 1'b0;
    state_nxt     = state_r;
    flag_nxt      = flag_r;
    which_nxt     = which_r;
    cur_nxt       = cur_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    last_nxt      = last_r;
    sroot_nxt     = sroot_r;
    droot_nxt     = droot_r;
    srank_nxt     = srank_r;
    drank_nxt     = drank_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_addr      = cur_r;
    ram_wdata     = '{is_root: 1'b0, parent: cur_root, rank: '0};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          src_nxt  = in_data.src_node;
          dst_nxt  = in_data.dest_node;
          last_nxt = in_data.last_edge;
          if (in_bad || flag_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{closes_cycle: 1'b0, cycle_seen: flag_r, src_root: '0,
                              dest_root: '0, bad_node: in_bad,
                              graph_done: in_data.last_edge};
            if (in_data.last_edge) begin
              flag_nxt    = 1'b0;
              clr_idx_nxt = '0;
              state_nxt   = S_CLEAR;
            end
          end else begin
            which_nxt = 1'b0;
            cur_nxt   = in_data.src_node;
            state_nxt = S_WRQ;
          end
        end
      end
      S_WRQ: begin
        ram_addr  = cur_r;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (rd_entry.is_root) begin
          if (which_r) begin
            droot_nxt = cur_r;
            drank_nxt = rd_entry.rank;
          end else begin
            sroot_nxt = cur_r;
            srank_nxt = rd_entry.rank;
          end
          if (cur_r == start_node) begin
            phase_done = 1'b1;
          end else begin
            cur_nxt   = start_node;
            state_nxt = S_CRQ;
          end
        end else begin
          cur_nxt  = rd_entry.parent;
          ram_addr = rd_entry.parent;
        end
      end
      S_CRQ: begin
        ram_addr  = cur_r;
        state_nxt = S_CRD;
      end
      S_CRD: begin
        ram_we    = 1'b1;
        ram_addr  = cur_r;
        ram_wdata = '{is_root: 1'b0, parent: cur_root, rank: '0};
        if (rd_entry.parent == cur_root) begin
          phase_done = 1'b1;
        end else begin
          cur_nxt   = rd_entry.parent;
          state_nxt = S_CRQ;
        end
      end
      S_JOIN: begin
        if (sroot_r == droot_r) begin
          flag_nxt      = !last_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{closes_cycle: 1'b1, cycle_seen: 1'b1, src_root: sroot_r,
                            dest_root: droot_r, bad_node: 1'b0, graph_done: last_r};
          clr_idx_nxt   = '0;
          state_nxt     = last_r ? S_CLEAR : S_IDLE;
        end else begin
          ram_we = 1'b1;
          if (srank_r < drank_r) begin
            ram_addr  = sroot_r;
            ram_wdata = '{is_root: 1'b0, parent: droot_r, rank: srank_r};
          end else begin
            ram_addr  = droot_r;
            ram_wdata = '{is_root: 1'b0, parent: sroot_r, rank: drank_r};
          end
          if (srank_r == drank_r && srank_r != RANK_W'(RANK_MAX)) begin
            state_nxt = S_JOIN2;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{closes_cycle: 1'b0, cycle_seen: 1'b0, src_root: sroot_r,
                              dest_root: droot_r, bad_node: 1'b0, graph_done: last_r};
            clr_idx_nxt   = '0;
            state_nxt     = last_r ? S_CLEAR : S_IDLE;
          end
        end
      end
      S_JOIN2: begin
        ram_we        = 1'b1;
        ram_addr      = sroot_r;
        ram_wdata     = '{is_root: 1'b1, parent: '0, rank: srank_r + RANK_W'(1)};
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{closes_cycle: 1'b0, cycle_seen: 1'b0, src_root: sroot_r,
                          dest_root: droot_r, bad_node: 1'b0, graph_done: last_r};
        clr_idx_nxt   = '0;
        state_nxt     = last_r ? S_CLEAR : S_IDLE;
      end
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_addr    = clr_idx_r;
        ram_wdata   = '{is_root: 1'b1, parent: '0, rank: '0};
        clr_idx_nxt = clr_idx_r + NODE_W'(1);
        flag_nxt    = 1'b0;
        if (clr_idx_r == NODE_W'(MAX_NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (phase_done) begin
      if (which_r) begin
        state_nxt = S_JOIN;
      end else begin
        which_nxt = 1'b1;
        cur_nxt   = dst_r;
        state_nxt = S_WRQ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      flag_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      node_count_r <= CNT_W'(MAX_NODES);
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        node_count_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    which_r    <= which_nxt;
    cur_r      <= cur_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    last_r     <= last_nxt;
    sroot_r    <= sroot_nxt;
    droot_r    <= droot_nxt;
    srank_r    <= srank_nxt;
    drank_r    <= drank_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(accept))
    else $error("result without a transaction in work");

  a_close_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.closes_cycle |->
      out_data.cycle_seen && (out_data.src_root == out_data.dest_root))
    else $error("cycle reported with inconsistent roots or flag");

  a_bad_skipped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_node |->
      !out_data.closes_cycle && (out_data.src_root == '0) && (out_data.dest_root == '0))
    else $error("out-of-range edge was processed");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.graph_done |-> busy && !flag_r)
    else $error("graph end did not start the clearing pass");

endmodule

@@ verif/ufcd_checker.sv @@
// Checker for the union-find cycle detector: tracks the forest from accepted edges
// and node_count writes, predicts each verdict and compares it with the DUT output.
// Depends on ufcd_pkg.
module ufcd_checker #(
  parameter logic [ufcd_pkg::APB_AW-1:0] NODE_COUNT_ADDR = '0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  ufcd_pkg::in_item_t          in_data,
  input  logic                        out_valid,
  input  ufcd_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ufcd_pkg::APB_AW-1:0] paddr,
  input  logic [ufcd_pkg::APB_DW-1:0] pwdata,
  output int                          mismatch_count,
  output int                          verdicts_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import ufcd_pkg::*;

  logic [NODE_W-1:0] link_to  [MAX_NODES];
  bit                is_root  [MAX_NODES];
  logic [RANK_W-1:0] set_rank [MAX_NODES];
  bit                graph_has_cycle;
  logic [CNT_W-1:0]  node_count;
  out_item_t         expected_verdicts [$];
  int                mismatch_total = 0;

  function automatic void clear_forest();
    for (int i = 0; i < MAX_NODES; i++) begin
      is_root[i]  = 1'b1;
      set_rank[i] = '0;
      link_to[i]  = '0;
    end
    graph_has_cycle = 1'b0;
  endfunction

  function automatic logic [NODE_W-1:0] find_and_compress(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] root;
    logic [NODE_W-1:0] cur;
    logic [NODE_W-1:0] nxt;
    root = node;
    while (!is_root[root]) root = link_to[root];
    cur = node;
    while (cur != root && !is_root[cur]) begin
      nxt          = link_to[cur];
      link_to[cur] = root;
      cur          = nxt;
    end
    return root;
  endfunction

  function automatic void join_sets(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
    if (set_rank[a] > set_rank[b]) begin
      link_to[b] = a;
      is_root[b] = 1'b0;
    end else if (set_rank[a] < set_rank[b]) begin
      link_to[a] = b;
      is_root[a] = 1'b0;
    end else begin
      // tie: dest root goes under src root, rank saturates
      link_to[b] = a;
      is_root[b] = 1'b0;
      if (set_rank[a] != RANK_W'(RANK_MAX)) set_rank[a] = set_rank[a] + RANK_W'(1);
    end
  endfunction

  function automatic out_item_t predict_edge_verdict(input in_item_t e);
    out_item_t v;
    int        limit;
    limit = (int'(node_count) < MAX_NODES) ? int'(node_count) : MAX_NODES;
    v = '0;
    v.bad_node   = (int'(e.src_node) >= limit) || (int'(e.dest_node) >= limit);
    v.graph_done = e.last_edge;
    if (!v.bad_node && !graph_has_cycle) begin
      v.src_root  = find_and_compress(e.src_node);
      v.dest_root = find_and_compress(e.dest_node);
      if (v.src_root == v.dest_root) begin
        v.closes_cycle  = 1'b1;
        graph_has_cycle = 1'b1;
      end else begin
        join_sets(v.src_root, v.dest_root);
      end
    end
    v.cycle_seen = graph_has_cycle;
    if (e.last_edge) clear_forest();
    return v;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_total++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_forest();
      node_count = CNT_W'(MAX_NODES);
      expected_verdicts.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == NODE_COUNT_ADDR)
        node_count = pwdata[CNT_W-1:0];
      if (out_valid) begin
        if (expected_verdicts.size() == 0) begin
          $error("result transaction with no edge pending: %h", out_data);
          mismatch_total++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("closes_cycle", 32'(want.closes_cycle), 32'(out_data.closes_cycle));
          check_field("cycle_seen", 32'(want.cycle_seen), 32'(out_data.cycle_seen));
          check_field("src_root", 32'(want.src_root), 32'(out_data.src_root));
          check_field("dest_root", 32'(want.dest_root), 32'(out_data.dest_root));
          check_field("bad_node", 32'(want.bad_node), 32'(out_data.bad_node));
          check_field("graph_done", 32'(want.graph_done), 32'(out_data.graph_done));
        end
      end
      if (start && !busy) expected_verdicts.push_back(predict_edge_verdict(in_data));
    end
    mismatch_count <= mismatch_total;
    verdicts_owed  <= expected_verdicts.size();
  end

endmodule

@@ verif/tb_union_find_cycle_detector_unit.sv @@
// Testbench top for the union-find cycle detector: clock, reset, edge and node_count
// stimulus, and the final verdict. Checking is done by ufcd_checker.
// Depends on ufcd_pkg, ufcd_checker and union_find_cycle_detector_unit.
module tb_union_find_cycle_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ufcd_pkg::*;

  localparam logic [APB_AW-1:0] NODE_COUNT_ADDR = '0;
  localparam int CYCLE_LIMIT    = 3_000_000;
  localparam int EDGES_PER_PHASE = 385;
  localparam int DRAIN_CYCLES   = 100;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  in_item_t          in_data = '0;
  logic              out_valid;
  out_item_t         out_data;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int mismatch_count;
  int verdicts_owed;
  int cycle_count = 0;
  int node_limit  = MAX_NODES;
  int edges_sent  = 0;

  union_find_cycle_detector_unit i_dut (.*);

  ufcd_checker #(.NODE_COUNT_ADDR(NODE_COUNT_ADDR)) i_verdict_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatch_count(mismatch_count),
    .verdicts_owed (verdicts_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_edge(input int unsigned s, input int unsigned d, input bit last);
    in_item_t e;
    e.src_node  = s[NODE_W-1:0];
    e.dest_node = d[NODE_W-1:0];
    e.last_edge = last;
    start   <= 1'b1;
    in_data <= e;
    do @(posedge clk); while (busy);
    edges_sent++;
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (verdicts_owed != 0);
  endtask

  task automatic write_node_count(input int unsigned v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NODE_COUNT_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    node_limit = ((v & 32'h7FF) < MAX_NODES) ? (v & 32'h7FF) : MAX_NODES;
  endtask

  // mostly spanning-tree edges over shuffled nodes, some cycle closers and noise
  task automatic run_graph(input int n_edges, input int idle_pct);
    int unsigned pick [MAX_NODES];
    int unsigned s;
    int unsigned d;
    int unsigned tmp;
    int          joined;
    int          j;
    int          roll;
    joined = 1;
    for (int i = 0; i < node_limit; i++) pick[i] = i;
    for (int i = 0; i < node_limit - 1 && i <= n_edges; i++) begin
      j       = $urandom_range(node_limit - 1, i);
      tmp     = pick[i];
      pick[i] = pick[j];
      pick[j] = tmp;
    end
    for (int k = 0; k < n_edges; k++) begin
      roll = $urandom_range(99);
      if (roll < 6 || node_limit < 2) begin
        s = $urandom_range(MAX_NODES - 1);
        d = $urandom_range(MAX_NODES - 1);
      end else if (roll < 10 || joined >= node_limit) begin
        s = pick[$urandom_range(joined - 1)];
        d = pick[$urandom_range(joined - 1)];
      end else begin
        s = pick[joined];
        d = pick[$urandom_range(joined - 1)];
        joined++;
        if ($urandom_range(1)) begin
          tmp = s;
          s   = d;
          d   = tmp;
        end
      end
      idle_gap(idle_pct);
      send_edge(s, d, k == n_edges - 1);
    end
  endtask

  initial begin
    int nc;
    int idle_pct;
    int target;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, cycle close, later edges of the graph ignored
    send_edge(0, 1023, 1'b0);
    send_edge(1023, 0, 1'b0);
    send_edge(5, 6, 1'b0);
    send_edge(7, 8, 1'b1);
    // rank tie, lower rank under higher both ways, cycle through compressed paths
    send_edge(2, 3, 1'b0);
    send_edge(4, 5, 1'b0);
    send_edge(2, 4, 1'b0);
    send_edge(6, 3, 1'b0);
    send_edge(3, 8, 1'b0);
    send_edge(5, 3, 1'b0);
    send_edge(1, 1, 1'b1);
    // self loop
    send_edge(7, 7, 1'b0);
    send_edge(1, 2, 1'b1);
    // node_count change in the middle of a graph keeps the forest
    send_edge(10, 11, 1'b0);
    send_edge(12, 10, 1'b0);
    wait_drained();
    write_node_count(12);
    send_edge(11, 12, 1'b0);
    send_edge(11, 10, 1'b0);
    send_edge(12, 13, 1'b1);
    wait_drained();
    write_node_count(0);
    send_edge(0, 0, 1'b0);
    send_edge(0, 1, 1'b1);
    wait_drained();
    write_node_count(1);
    send_edge(0, 0, 1'b0);
    send_edge(0, 1, 1'b1);
    wait_drained();
    write_node_count(2047);
    send_edge(1023, 0, 1'b0);
    send_edge(1022, 1023, 1'b0);
    send_edge(1022, 0, 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          nc       = MAX_NODES;
          idle_pct = 0;
        end
        1: begin
          nc       = $urandom_range(64, 2);
          idle_pct = 83;
        end
        2: begin
          nc       = 2047;
          idle_pct = 0;
        end
        default: begin
          nc       = $urandom_range(MAX_NODES, 2);
          idle_pct = 31;
        end
      endcase
      wait_drained();
      write_node_count(nc);
      target = edges_sent + EDGES_PER_PHASE;
      while (edges_sent < target)
        run_graph(($urandom_range(9) == 0) ? $urandom_range(200, 31) : $urandom_range(30, 1),
                  idle_pct);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && verdicts_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
